// ----- rtl/srle_pkg.sv -----
package srle_pkg;

   // Opcodes found in bits 31..24 of an opcode word.
   localparam logic [7:0] OP_END    = 8'd0;
   localparam logic [7:0] OP_LINE   = 8'd1;
   localparam logic [7:0] OP_PIXELS = 8'd2;
   localparam logic [7:0] OP_SKIP   = 8'd3;
   localparam logic [7:0] OP_RUN    = 8'd4;

   // Result kinds.
   localparam logic [1:0] KIND_PIXELS = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FRAME_TOTAL  = 2'd2;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 24;
   localparam int DIM_W   = 10;
   localparam int LINE_W  = 11;
   localparam int COLOR_W = 16;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LITERAL,
      DP_PATTERN,
      DP_DONE,
      DP_ERROR,
      DP_NEXT_FRAME,
      DP_LINE_INC,
      DP_OFFSET_MUL,
      DP_OFFSET_ADD,
      DP_SET_BYTES,
      DP_SKIP,
      DP_SET_RUN
   } dp_op_type;

   typedef struct packed {
      logic      load;
      logic      clear;
      dp_op_type op;
   } srle_cmd_type;

   typedef struct packed {
      logic       first_word;
      logic [7:0] opcode;
      logic       count_zero;
      logic       line_match;
      logic       frame_last;
      logic       run_zero;
      logic       lit_last;
      logic       out_free;
   } srle_stat_type;

endpackage

// ----- rtl/srle_req_if.sv -----
interface srle_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] stream_word;
   logic        first_word;

   modport source (output valid, output stream_word, output first_word, input ready);
   modport sink   (input valid, input stream_word, input first_word, output ready);
endinterface

// ----- rtl/srle_rsp_if.sv -----
interface srle_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] pixel_offset;
   logic [23:0] pixel_count;
   logic [15:0] color_even;
   logic [15:0] color_odd;

   modport source (output valid, output result_kind, output pixel_offset,
                   output pixel_count, output color_even, output color_odd, input ready);
   modport sink   (input valid, input result_kind, input pixel_offset,
                   input pixel_count, input color_even, input color_odd, output ready);
endinterface

// ----- rtl/srle_ctrl.sv -----
module srle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  srle_pkg::srle_stat_type stat,
   output srle_pkg::srle_cmd_type  cmd
);
   import srle_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_OFFSET_MUL,
      S_OFFSET_ADD
   } state_type;

   typedef enum logic [1:0] {
      PH_OPCODE,
      PH_LITERAL,
      PH_PATTERN,
      PH_HALTED
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.clear = 1'b0;
      cmd.op    = DP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.clear = stat.first_word;
               if (stat.first_word) begin
                  phase_in = PH_OPCODE;
               end
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (phase_ff)
               PH_LITERAL: begin
                  if (stat.out_free) begin
                     cmd.op = DP_LITERAL;
                     if (stat.lit_last) begin
                        phase_in = PH_OPCODE;
                     end
                     state_in = S_IDLE;
                  end
               end
               PH_PATTERN: begin
                  if (stat.run_zero) begin
                     phase_in = PH_OPCODE;
                     state_in = S_IDLE;
                  end else if (stat.out_free) begin
                     cmd.op   = DP_PATTERN;
                     phase_in = PH_OPCODE;
                     state_in = S_IDLE;
                  end
               end
               PH_HALTED: begin
                  state_in = S_IDLE;
               end
               PH_OPCODE: begin
                  unique case (stat.opcode)
                     OP_END: begin
                        priority if (!stat.line_match) begin
                           if (stat.out_free) begin
                              cmd.op   = DP_ERROR;
                              phase_in = PH_HALTED;
                              state_in = S_IDLE;
                           end
                        end else if (stat.frame_last) begin
                           if (stat.out_free) begin
                              cmd.op   = DP_DONE;
                              phase_in = PH_HALTED;
                              state_in = S_IDLE;
                           end
                        end else begin
                           cmd.op   = DP_NEXT_FRAME;
                           state_in = S_IDLE;
                        end
                     end
                     OP_LINE: begin
                        cmd.op   = DP_LINE_INC;
                        state_in = S_OFFSET_MUL;
                     end
                     OP_PIXELS: begin
                        cmd.op = DP_SET_BYTES;
                        if (!stat.count_zero) begin
                           phase_in = PH_LITERAL;
                        end
                        state_in = S_IDLE;
                     end
                     OP_SKIP: begin
                        cmd.op   = DP_SKIP;
                        state_in = S_IDLE;
                     end
                     OP_RUN: begin
                        cmd.op   = DP_SET_RUN;
                        phase_in = PH_PATTERN;
                        state_in = S_IDLE;
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_OFFSET_MUL: begin
            cmd.op   = DP_OFFSET_MUL;
            state_in = S_OFFSET_ADD;
         end
         S_OFFSET_ADD: begin
            cmd.op   = DP_OFFSET_ADD;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_OPCODE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- rtl/srle_dpath.sv -----
module srle_dpath #(
   parameter int GRID_COLUMNS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             req_stream_word,
   input  logic                    req_first_word,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [9:0]              csr_wdata,
   input  srle_pkg::srle_cmd_type  cmd,
   output srle_pkg::srle_stat_type stat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_result_kind,
   output logic [31:0]             rsp_pixel_offset,
   output logic [23:0]             rsp_pixel_count,
   output logic [15:0]             rsp_color_even,
   output logic [15:0]             rsp_color_odd
);
   import srle_pkg::*;

   localparam int COL_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;

   // Configuration.
   logic [DIM_W-1:0] fw_ff, fh_ff, ft_ff;

   // Stream state.
   logic [WORD_W-1:0]  word_ff;
   logic [COUNT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [COUNT_W-1:0] run_bytes_ff;
   logic [LINE_W-1:0]  line_ff;
   logic [DIM_W-1:0]   frame_ff;
   logic [COL_W-1:0]   col_ff;
   logic [DIM_W-1:0]   row_ff;
   logic [WORD_W-1:0]  offset_ff;

   // Line start offset pipeline.
   logic [2*DIM_W-1:0]     row_h_ff;
   logic [2*DIM_W-1:0]     surf_w_ff;
   logic [COL_W+DIM_W-1:0] col_x_ff;
   logic [WORD_W-1:0]      prod_ff;

   // Result register.
   logic               out_valid_ff, out_load;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic [WORD_W-1:0]  out_offset_ff;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [COLOR_W-1:0] out_even_ff, out_even_in;
   logic [COLOR_W-1:0] out_odd_ff, out_odd_in;

   logic [7:0]          opcode;
   logic [COUNT_W-1:0]  count;
   logic [COUNT_W-1:0]  lit_n;
   logic [COUNT_W-1:0]  pat_n;
   logic [COUNT_W:0]    run_sum;
   logic [DIM_W-1:0]    cols;
   logic [LINE_W-1:0]   frame_next;
   logic [2*DIM_W:0]    line_y;
   logic [3*DIM_W+LINE_W-1:0] y_prod;

   assign opcode  = word_ff[31:24];
   assign count   = word_ff[23:0];
   assign lit_n   = (bytes_left_ff >= COUNT_W'(3)) ? COUNT_W'(2) : COUNT_W'(1);
   assign run_sum = {1'b0, run_bytes_ff} + (COUNT_W+1)'(1);
   assign pat_n   = run_sum[COUNT_W:1];
   assign cols    = (ft_ff < DIM_W'(GRID_COLUMNS)) ? ft_ff : DIM_W'(GRID_COLUMNS);
   assign frame_next = {1'b0, frame_ff} + LINE_W'(1);
   assign line_y  = {1'b0, row_h_ff} + (2*DIM_W+1)'(line_ff);
   assign y_prod  = line_y * surf_w_ff;

   assign bytes_left_in = (bytes_left_ff >= COUNT_W'(4)) ? bytes_left_ff - COUNT_W'(4)
                                                         : '0;

   assign stat.first_word = req_first_word;
   assign stat.opcode     = opcode;
   assign stat.count_zero = (count == '0);
   assign stat.line_match = (line_ff == ({1'b0, fh_ff} - LINE_W'(1)));
   assign stat.frame_last = (frame_next >= {1'b0, ft_ff});
   assign stat.run_zero   = (run_bytes_ff == '0);
   assign stat.lit_last   = (bytes_left_ff <= COUNT_W'(4));
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      out_load     = 1'b0;
      out_kind_in  = KIND_PIXELS;
      out_count_in = '0;
      out_even_in  = '0;
      out_odd_in   = '0;
      unique case (cmd.op)
         DP_LITERAL: begin
            out_load     = 1'b1;
            out_count_in = lit_n;
            out_even_in  = word_ff[31:16];
            out_odd_in   = word_ff[15:0];
         end
         DP_PATTERN: begin
            out_load     = 1'b1;
            out_count_in = pat_n;
            out_even_in  = word_ff[31:16];
            out_odd_in   = word_ff[15:0];
         end
         DP_DONE: begin
            out_load    = 1'b1;
            out_kind_in = KIND_DONE;
         end
         DP_ERROR: begin
            out_load    = 1'b1;
            out_kind_in = KIND_ERROR;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
      // A single pixel carries no odd color.
      if (out_count_in == COUNT_W'(1)) begin
         out_odd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff         <= DIM_W'(1);
         fh_ff         <= DIM_W'(1);
         ft_ff         <= DIM_W'(1);
         bytes_left_ff <= '0;
         run_bytes_ff  <= '0;
         line_ff       <= '1;
         frame_ff      <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         offset_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_FRAME_WIDTH:  fw_ff <= csr_wdata;
               REG_FRAME_HEIGHT: fh_ff <= csr_wdata;
               REG_FRAME_TOTAL:  ft_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (cmd.clear) begin
            bytes_left_ff <= '0;
            run_bytes_ff  <= '0;
            line_ff       <= '1;
            frame_ff      <= '0;
            col_ff        <= '0;
            row_ff        <= '0;
            offset_ff     <= '0;
         end

         unique case (cmd.op)
            DP_LITERAL: begin
               bytes_left_ff <= bytes_left_in;
               offset_ff     <= offset_ff + WORD_W'(lit_n);
            end
            DP_PATTERN: begin
               run_bytes_ff <= '0;
               offset_ff    <= offset_ff + WORD_W'(pat_n);
            end
            DP_NEXT_FRAME: begin
               frame_ff <= frame_next[DIM_W-1:0];
               line_ff  <= '1;
               if (col_ff == COL_W'(GRID_COLUMNS - 1)) begin
                  col_ff <= '0;
                  row_ff <= row_ff + DIM_W'(1);
               end else begin
                  col_ff <= col_ff + COL_W'(1);
               end
            end
            DP_LINE_INC: begin
               line_ff <= line_ff + LINE_W'(1);
            end
            DP_OFFSET_ADD: begin
               offset_ff <= prod_ff + WORD_W'(col_x_ff);
            end
            DP_SET_BYTES: begin
               bytes_left_ff <= count;
            end
            DP_SKIP: begin
               offset_ff <= offset_ff + WORD_W'(count[COUNT_W-1:1]);
            end
            DP_SET_RUN: begin
               run_bytes_ff <= count;
            end
            default: begin
            end
         endcase

         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_stream_word;
      end
      if (cmd.op == DP_LINE_INC) begin
         row_h_ff  <= row_ff * fh_ff;
         surf_w_ff <= cols * fw_ff;
         col_x_ff  <= col_ff * fw_ff;
      end
      if (cmd.op == DP_OFFSET_MUL) begin
         prod_ff <= y_prod[WORD_W-1:0];
      end
      if (out_load) begin
         out_kind_ff   <= out_kind_in;
         out_offset_ff <= (out_kind_in == KIND_PIXELS) ? offset_ff : '0;
         out_count_ff  <= out_count_in;
         out_even_ff   <= out_even_in;
         out_odd_ff    <= out_odd_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_pixel_offset = out_offset_ff;
   assign rsp_pixel_count  = out_count_ff;
   assign rsp_color_even   = out_even_ff;
   assign rsp_color_odd    = out_odd_ff;

endmodule

// ----- rtl/sprite_rle_stream_decoder_core.sv -----
// Decoder for the frame data of a 16-bit sprite run-length stream. Each request word is one
// 32-bit word of frame data; an opcode word holds the opcode in bits 31..24 (0 end of frame,
// 1 line start, 2 pixel data, 3 transparent run, 4 pixel run) and a byte count in bits 23..0.
// Each response word describes one pixel write or fill (offset, count and the two alternating
// colors), or reports that all frames are done or that a frame had the wrong number of
// scanlines. After done or an error every word is dropped until one arrives with first_word
// set, which also restarts frame, line and offset tracking. A word is accepted, then decoded
// and executed; a line start word adds the offset multiply and add states, because the new
// line offset comes from a chain of multiplies that is spread over two registered stages of
// the datapath. A word that produces a result waits in its decode state while the response
// register still holds an earlier result that has not been taken. Configuration registers
// (frame_width, frame_height, frame_total at indexes 0, 1 and 2) should be written only while
// the decoder is idle; other indexes are ignored.
module sprite_rle_stream_decoder_core #(
   parameter int GRID_COLUMNS = 6
) (
   input  logic              clock,
   input  logic              reset,
   srle_req_if.sink          req,
   srle_rsp_if.source        rsp,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_wdata
);
   import srle_pkg::*;

   // Command and status between the sequencer and the datapath.
   srle_cmd_type  cmd;
   srle_stat_type stat;

   // The sequencer owns the decode phase and the handshake on the request side.
   srle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds configuration, stream position, the line offset multipliers and
   // the response register.
   srle_dpath #(
      .GRID_COLUMNS (GRID_COLUMNS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_stream_word  (req.stream_word),
      .req_first_word   (req.first_word),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_result_kind  (rsp.result_kind),
      .rsp_pixel_offset (rsp.pixel_offset),
      .rsp_pixel_count  (rsp.pixel_count),
      .rsp_color_even   (rsp.color_even),
      .rsp_color_odd    (rsp.color_odd)
   );

endmodule
